// ===== sv/arpc_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and control types of the ARP cache with aging.
// No dependencies; used by every module of the block.
package arpc_pkg;

   localparam int ENTRIES_DEF = 8;

   localparam int IP_W     = 32;
   localparam int MAC_W    = 48;
   localparam int TIME_W   = 32;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 3;
   localparam int INDEX_W  = 6;
   localparam int COUNT_W  = 7;
   localparam int CSR_A_W  = 2;

   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
   localparam logic [OP_W-1:0] OP_UPDATE = 2'd1;
   localparam logic [OP_W-1:0] OP_AGE    = 2'd2;
   localparam logic [OP_W-1:0] OP_RSVD   = 2'd3;

   localparam logic [STATUS_W-1:0] ST_HIT     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_MISS    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BCAST   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_REFRESH = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FILL    = 3'd4;
   localparam logic [STATUS_W-1:0] ST_REPLACE = 3'd5;
   localparam logic [STATUS_W-1:0] ST_AGED    = 3'd6;
   localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd7;

   localparam logic [CSR_A_W-1:0] CSR_HOST_IP    = 2'd0;
   localparam logic [CSR_A_W-1:0] CSR_GATEWAY_IP = 2'd1;
   localparam logic [CSR_A_W-1:0] CSR_SUBNET     = 2'd2;
   localparam logic [CSR_A_W-1:0] CSR_MAX_AGE    = 2'd3;

   localparam logic [TIME_W-1:0] MAX_AGE_RST = 32'd60000;
   localparam logic [IP_W-1:0]   BCAST_MASK  = 32'hFF00_0000;
   localparam logic [MAC_W-1:0]  MAC_BCAST   = {MAC_W{1'b1}};

   typedef struct packed {
      logic load;
      logic scan;
      logic write;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic quick;
      logic hit;
      logic last;
      logic upd;
      logic out_free;
   } sts_type;

endpackage

// ===== sv/arpc_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer of the ARP cache: accept, table scan, entry write, result load.
// Depends on arpc_pkg for the command and status types.
module arpc_ctrl import arpc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SCAN   = 4'b0010,
      S_WRITE  = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_stall  = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.quick || sts.hit) begin
               state_in = S_FINISH;
            end else if (sts.last) begin
               state_in = sts.upd ? S_WRITE : S_FINISH;
            end
         end
         S_WRITE: begin
            cmd.write = 1'b1;
            state_in  = S_FINISH;
         end
         S_FINISH: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/arpc_dpath.sv =====
`timescale 1ns / 1ps
// Datapath of the ARP cache: settings, entry tables, scan trackers, result register.
// Depends on arpc_pkg; driven by arpc_ctrl through cmd_type and sts_type.
module arpc_dpath import arpc_pkg::*; #(
   parameter int ENTRIES = ENTRIES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [OP_W-1:0]     req_op,
   input  logic [IP_W-1:0]     req_ip_addr,
   input  logic [MAC_W-1:0]    req_hw_addr,
   input  logic [TIME_W-1:0]   req_now_ms,
   input  logic                csr_valid,
   input  logic [CSR_A_W-1:0]  csr_index,
   input  logic [IP_W-1:0]     csr_wdata,
   input  cmd_type             cmd,
   output sts_type             sts,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [MAC_W-1:0]    rsp_mac_out,
   output logic [IP_W-1:0]     rsp_next_hop_ip,
   output logic [INDEX_W-1:0]  rsp_entry_index,
   output logic [COUNT_W-1:0]  rsp_cleared_count
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);

   logic [IP_W-1:0]   host_ff, gate_ff, mask_ff;
   logic [TIME_W-1:0] max_age_ff;

   logic [IP_W-1:0]   mem_ip    [ENTRIES];
   logic [MAC_W-1:0]  mem_mac   [ENTRIES];
   logic [TIME_W-1:0] mem_stamp [ENTRIES];
   logic [IP_W-1:0]   rd_ip_ff;
   logic [MAC_W-1:0]  rd_mac_ff;
   logic [TIME_W-1:0] rd_stamp_ff;

   logic [ENTRIES-1:0] vld_ff, vld_in;

   logic [OP_W-1:0]   op_ff;
   logic [IP_W-1:0]   key_ff, key_in, hop;
   logic [MAC_W-1:0]  mac_ff;
   logic [TIME_W-1:0] now_ff;
   logic              bcast_ff, bcast_in;
   logic              zero_ff;
   logic              quick_ff, quick_in;

   logic [CNT_W-1:0] rd_cnt_ff;
   logic             rd_more;
   logic             chk_vld_ff;
   logic [IDX_W-1:0] chk_idx_ff;

   logic              ev, match_now, aged_now;
   logic [TIME_W-1:0] age;

   logic              match_fnd_ff;
   logic [IDX_W-1:0]  match_idx_ff;
   logic [MAC_W-1:0]  match_mac_ff;
   logic              empty_fnd_ff;
   logic [IDX_W-1:0]  empty_idx_ff;
   logic [TIME_W-1:0] old_age_ff;
   logic [IDX_W-1:0]  old_idx_ff;
   logic [CNT_W-1:0]  clr_cnt_ff;
   logic [IDX_W-1:0]  wr_pos;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] res_status;
   logic [MAC_W-1:0]    res_mac;
   logic [IP_W-1:0]     res_hop;
   logic [IDX_W-1:0]    res_idx;
   logic [COUNT_W-1:0]  res_cnt;
   logic [STATUS_W-1:0] status_ff;
   logic [MAC_W-1:0]    mac_out_ff;
   logic [IP_W-1:0]     hop_out_ff;
   logic [INDEX_W-1:0]  idx_out_ff;
   logic [COUNT_W-1:0]  cnt_out_ff;

   // next hop and request classification at accept
   always_comb begin
      if (host_ff == gate_ff) begin
         hop = req_ip_addr;
      end else if ((req_ip_addr & mask_ff) != (host_ff & mask_ff)) begin
         hop = gate_ff;
      end else begin
         hop = req_ip_addr;
      end
      key_in   = (req_op == OP_LOOKUP) ? hop : req_ip_addr;
      bcast_in = (req_op == OP_LOOKUP) && ((req_ip_addr & BCAST_MASK) == BCAST_MASK);
      case (req_op)
         OP_LOOKUP: quick_in = bcast_in || (key_in == '0);
         OP_UPDATE: quick_in = (key_in == '0);
         OP_AGE:    quick_in = 1'b0;
         default:   quick_in = 1'b1;
      endcase
   end

   assign rd_more   = rd_cnt_ff < CNT_W'(ENTRIES);
   assign ev        = cmd.scan && chk_vld_ff;
   assign age       = now_ff - rd_stamp_ff;
   assign match_now = vld_ff[chk_idx_ff] && (rd_ip_ff == key_ff);
   assign aged_now  = vld_ff[chk_idx_ff] && (age >= max_age_ff);

   assign wr_pos = match_fnd_ff ? match_idx_ff : (empty_fnd_ff ? empty_idx_ff : old_idx_ff);

   assign sts.quick    = quick_ff;
   assign sts.hit      = ev && (op_ff == OP_LOOKUP) && match_now;
   assign sts.last     = ev && (chk_idx_ff == IDX_W'(ENTRIES - 1));
   assign sts.upd      = (op_ff == OP_UPDATE);
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      vld_in = vld_ff;
      if (ev && (op_ff == OP_AGE) && aged_now) begin
         vld_in[chk_idx_ff] = 1'b0;
      end
      if (cmd.write) begin
         vld_in[wr_pos] = 1'b1;
      end
   end

   always_comb begin
      res_status = ST_IGNORED;
      res_mac    = '0;
      res_hop    = '0;
      res_idx    = '0;
      res_cnt    = '0;
      case (op_ff)
         OP_LOOKUP: begin
            if (bcast_ff) begin
               res_status = ST_BCAST;
               res_mac    = MAC_BCAST;
               res_hop    = key_ff;
            end else if (!zero_ff) begin
               res_hop = key_ff;
               if (match_fnd_ff) begin
                  res_status = ST_HIT;
                  res_mac    = match_mac_ff;
                  res_idx    = match_idx_ff;
               end else begin
                  res_status = ST_MISS;
               end
            end
         end
         OP_UPDATE: begin
            if (!zero_ff) begin
               res_idx = wr_pos;
               if (match_fnd_ff) begin
                  res_status = ST_REFRESH;
               end else if (empty_fnd_ff) begin
                  res_status = ST_FILL;
               end else begin
                  res_status = ST_REPLACE;
               end
            end
         end
         OP_AGE: begin
            res_status = ST_AGED;
            res_cnt    = COUNT_W'(clr_cnt_ff);
         end
         default: begin
            res_status = ST_IGNORED;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         host_ff      <= '0;
         gate_ff      <= '0;
         mask_ff      <= '0;
         max_age_ff   <= MAX_AGE_RST;
         vld_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_HOST_IP:    host_ff    <= csr_wdata;
               CSR_GATEWAY_IP: gate_ff    <= csr_wdata;
               CSR_SUBNET:     mask_ff    <= csr_wdata;
               CSR_MAX_AGE:    max_age_ff <= csr_wdata;
               default:        host_ff    <= host_ff;
            endcase
         end
         vld_ff     <= vld_in;
         chk_vld_ff <= cmd.scan && rd_more;
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_ip_ff    <= mem_ip[rd_cnt_ff[IDX_W-1:0]];
      rd_mac_ff   <= mem_mac[rd_cnt_ff[IDX_W-1:0]];
      rd_stamp_ff <= mem_stamp[rd_cnt_ff[IDX_W-1:0]];
      if (cmd.write) begin
         mem_ip[wr_pos]    <= key_ff;
         mem_mac[wr_pos]   <= mac_ff;
         mem_stamp[wr_pos] <= now_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff        <= req_op;
         key_ff       <= key_in;
         mac_ff       <= req_hw_addr;
         now_ff       <= req_now_ms;
         bcast_ff     <= bcast_in;
         zero_ff      <= (key_in == '0);
         quick_ff     <= quick_in;
         rd_cnt_ff    <= '0;
         match_fnd_ff <= 1'b0;
         empty_fnd_ff <= 1'b0;
         old_age_ff   <= '0;
         old_idx_ff   <= '0;
         clr_cnt_ff   <= '0;
      end else begin
         if (cmd.scan && rd_more) begin
            rd_cnt_ff  <= rd_cnt_ff + CNT_W'(1);
            chk_idx_ff <= rd_cnt_ff[IDX_W-1:0];
         end
         if (ev) begin
            if (match_now && !match_fnd_ff) begin
               match_fnd_ff <= 1'b1;
               match_idx_ff <= chk_idx_ff;
               match_mac_ff <= rd_mac_ff;
            end
            if (!vld_ff[chk_idx_ff] && !empty_fnd_ff) begin
               empty_fnd_ff <= 1'b1;
               empty_idx_ff <= chk_idx_ff;
            end
            if (age > old_age_ff) begin
               old_age_ff <= age;
               old_idx_ff <= chk_idx_ff;
            end
            if ((op_ff == OP_AGE) && aged_now) begin
               clr_cnt_ff <= clr_cnt_ff + CNT_W'(1);
            end
         end
      end
      if (cmd.finish) begin
         status_ff  <= res_status;
         mac_out_ff <= res_mac;
         hop_out_ff <= res_hop;
         idx_out_ff <= INDEX_W'(res_idx);
         cnt_out_ff <= res_cnt;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_mac_out       = mac_out_ff;
   assign rsp_next_hop_ip   = hop_out_ff;
   assign rsp_entry_index   = idx_out_ff;
   assign rsp_cleared_count = cnt_out_ff;

endmodule

// ===== sv/arp_cache_with_aging.sv =====
`timescale 1ns / 1ps
// ARP cache with aging: an IPv4-to-MAC table with timestamps, oldest-entry replacement.
// Top level; instantiates arpc_ctrl and arpc_dpath, uses arpc_pkg.
//
// Usage:
//   req_*  one request: op (lookup, update, age sweep), ip_addr, hw_addr, now_ms.
//          Taken at a clock edge with req_valid high and req_stall low.
//   rsp_*  one result per request, held in an output register until taken
//          (rsp_valid high, rsp_stall low). While a result waits, the block
//          finishes its current request and then stalls in its final step.
//   csr_*  register writes (host, gateway, mask, max age), always ready;
//          write only while no request is in flight.
// Timing: the table is scanned one entry per cycle through a registered
//   memory read port. A lookup ends its scan at the first hit; a broadcast or
//   ignored request ends it at once. The result register loads in the final
//   step, after the scan (after the entry write for an update), once the output
//   register is free, and shows the next cycle.
// Reset: settings return to their defaults, all entries become empty, and no
//   result is pending. No clearing pass is needed.
module arp_cache_with_aging import arpc_pkg::*; #(
   parameter int ENTRIES = ENTRIES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OP_W-1:0]     req_op,
   input  logic [IP_W-1:0]     req_ip_addr,
   input  logic [MAC_W-1:0]    req_hw_addr,
   input  logic [TIME_W-1:0]   req_now_ms,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [MAC_W-1:0]    rsp_mac_out,
   output logic [IP_W-1:0]     rsp_next_hop_ip,
   output logic [INDEX_W-1:0]  rsp_entry_index,
   output logic [COUNT_W-1:0]  rsp_cleared_count,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CSR_A_W-1:0]  csr_index,
   input  logic [IP_W-1:0]     csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   arpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   arpc_dpath #(
      .ENTRIES (ENTRIES)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_op            (req_op),
      .req_ip_addr       (req_ip_addr),
      .req_hw_addr       (req_hw_addr),
      .req_now_ms        (req_now_ms),
      .csr_valid         (csr_valid & csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_mac_out       (rsp_mac_out),
      .rsp_next_hop_ip   (rsp_next_hop_ip),
      .rsp_entry_index   (rsp_entry_index),
      .rsp_cleared_count (rsp_cleared_count)
   );

endmodule

// ===== sv/arpc_chk.sv =====
`timescale 1ns / 1ps
// Port-level checker for the ARP cache, attached to the top level by bind.
// Depends on arpc_pkg for widths and status codes.
module arpc_chk import arpc_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [MAC_W-1:0]    rsp_mac_out,
   input logic [IP_W-1:0]     rsp_next_hop_ip,
   input logic [INDEX_W-1:0]  rsp_entry_index,
   input logic [COUNT_W-1:0]  rsp_cleared_count
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_mac_out)
         && $stable(rsp_next_hop_ip) && $stable(rsp_entry_index)
         && $stable(rsp_cleared_count))
      else $error("result changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while the previous one is in flight");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

   a_bcast_mac: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_BCAST) |-> (rsp_mac_out == MAC_BCAST)
         && (rsp_entry_index == '0))
      else $error("broadcast result without all-ones MAC");

   a_write_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_status == ST_REFRESH) || (rsp_status == ST_FILL)
         || (rsp_status == ST_REPLACE) || (rsp_status == ST_AGED)
         || (rsp_status == ST_IGNORED))
      |-> (rsp_mac_out == '0) && (rsp_next_hop_ip == '0))
      else $error("non-lookup result carries MAC or next hop");

endmodule

bind arp_cache_with_aging arpc_chk u_arpc_chk (.*);
